// ----- rtl/core/ppr_pkg.sv -----
package ppr_pkg;

  // Sample and register field widths
  localparam int unsigned PixelW      = 8;
  localparam int unsigned PlaneWidthW = 12;

  // Row store depth: longest row the block can hold
  localparam int unsigned MaxWidth = 2048;

  // Column index into the row store
  localparam int unsigned ColW = $clog2(MaxWidth);

  // Width used to compare a column against the effective row width
  localparam int unsigned EffW = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW = (EffW > PlaneWidthW) ? EffW : PlaneWidthW;

  // Reset value of the row width register
  localparam logic [PlaneWidthW-1:0] PlaneWidthRst = PlaneWidthW'(2048);

endpackage

// ----- rtl/core/ppr_cfg_if.sv -----
interface ppr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ppr_pkg::PlaneWidthW-1:0]  plane_width;

  modport source (output valid, output plane_width, input ready);
  modport sink   (input valid, input plane_width, output ready);
endinterface

// ----- rtl/core/ppr_pix_if.sv -----
interface ppr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::PixelW-1:0]  pixel;
  logic                        first_of_plane;

  modport source (output valid, output pixel, output first_of_plane, input ready);
  modport sink   (input valid, input pixel, input first_of_plane, output ready);
endinterface

// ----- rtl/core/ppr_res_if.sv -----
interface ppr_res_if;
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::PixelW-1:0]  residual;

  modport source (output valid, output residual, input ready);
  modport sink   (input valid, input residual, output ready);
endinterface

// ----- rtl/core/ppr_predict.sv -----
module ppr_predict (
  input  logic [ppr_pkg::PixelW-1:0] pixel_i,
  input  logic [ppr_pkg::PixelW-1:0] left_i,
  input  logic [ppr_pkg::PixelW-1:0] upper_i,
  input  logic [ppr_pkg::PixelW-1:0] upper_left_i,
  output logic [ppr_pkg::PixelW-1:0] residual_o
);

  localparam int unsigned PW    = ppr_pkg::PixelW;
  localparam int unsigned NumW  = PW + 3;      // signed 2L+2T-LT
  localparam int unsigned MagW  = PW + 2;      // magnitude, at most 4*255
  localparam int unsigned RecSh = MagW + 1;
  // ceil(2^RecSh / 3): exact floor(m/3) for every m below 2^MagW
  localparam int unsigned RecMul = ((1 << RecSh) + 2) / 3;
  localparam int unsigned ProdW  = 2 * MagW;

  logic signed [NumW-1:0] num;
  logic [MagW-1:0]        mag;
  logic [ProdW-1:0]       prod;
  logic [PW-1:0]          quot;
  logic [PW-1:0]          pred;

  always_comb begin
    num  = $signed(NumW'({left_i, 1'b0})) + $signed(NumW'({upper_i, 1'b0}))
         - $signed(NumW'(upper_left_i));
    mag  = num[NumW-1] ? MagW'(-num) : MagW'(num);
    // Divide the magnitude by three, then restore the sign: truncation toward zero
    prod = ProdW'(mag) * ProdW'(RecMul);
    quot = PW'(prod >> RecSh);
    pred = num[NumW-1] ? PW'(-quot) : quot;
    residual_o = pixel_i - pred;
  end

endmodule

// ----- rtl/core/plane_predictive_residual_unit.sv -----
// Gradient-prediction residual for one image plane. Samples arrive in raster
// order on pix_i, one request per sample; first_of_plane marks the top-left
// sample and restarts column and row. Each sample gives exactly one residual
// on res_o: (sample - (2L + 2T - LT) / 3) mod 256, the division truncated
// toward zero, with L, T and LT the original left, upper and upper-left
// samples and any neighbour outside the plane taken as zero. The row length
// comes from the plane_width register on cfg_i (reset 2048, zero acts as one,
// values above the row store depth saturate to it); write it only while the
// block is idle. Throughput is one sample per clock while res_o is ready: the
// single-port row store is read and written at the same column in the cycle
// a sample is taken, reading the previous row's value before it is replaced.
// An accepted request passes through the input register, beside the row
// store read data, and then the result register before its residual appears.
// The row store holds no valid bits; it needs no clearing after reset as long
// as a row is written before it is read, which the block does not enforce.
module plane_predictive_residual_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppr_cfg_if.sink    cfg_i,
  ppr_pix_if.sink    pix_i,
  ppr_res_if.source  res_o
);

  localparam int unsigned PW   = ppr_pkg::PixelW;
  localparam int unsigned ColW = ppr_pkg::ColW;
  localparam int unsigned CmpW = ppr_pkg::CmpW;

  // Configuration
  logic [ppr_pkg::PlaneWidthW-1:0] plane_width_q;
  logic [CmpW-1:0]                 eff_width;

  // Raster position of the next sample
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic            first_row_q, first_row_d;

  // Position of the sample being taken
  logic [ColW-1:0] col;
  logic            top_row;
  logic            col_zero;

  // Left neighbour for the next sample
  logic [PW-1:0] left_q;

  // Row store
  logic [PW-1:0] row_mem [ppr_pkg::MaxWidth];

  // Input stage
  logic          s1_valid_q;
  logic [PW-1:0] s1_pixel_q;
  logic [PW-1:0] s1_left_q;
  logic [PW-1:0] s1_upper_q;       // row store read data
  logic          s1_top_q;
  logic          s1_col_zero_q;

  // Result stage
  logic          out_valid_q;
  logic [PW-1:0] out_res_q;
  logic [PW-1:0] upper_left_q;     // T of the previous sample

  logic          accept;
  logic          s1_adv;
  logic [PW-1:0] upper;
  logic [PW-1:0] upper_left;
  logic [PW-1:0] residual;

  // Configuration port: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_width_q <= ppr_pkg::PlaneWidthRst;
    end else if (cfg_i.valid) begin
      plane_width_q <= cfg_i.plane_width;
    end
  end

  // Zero acts as one, anything above the store depth saturates
  always_comb begin
    if (plane_width_q == '0) begin
      eff_width = CmpW'(1);
    end else if (CmpW'(plane_width_q) > CmpW'(ppr_pkg::MaxWidth)) begin
      eff_width = CmpW'(ppr_pkg::MaxWidth);
    end else begin
      eff_width = CmpW'(plane_width_q);
    end
  end

  // Handshake: advance the input stage when the result register frees up
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  // Place the incoming sample; restart the row if the width shrank under us
  always_comb begin
    if (pix_i.first_of_plane) begin
      col     = '0;
      top_row = 1'b1;
    end else if (CmpW'(col_cnt_q) >= eff_width) begin
      col     = '0;
      top_row = 1'b0;
    end else begin
      col     = col_cnt_q;
      top_row = first_row_q;
    end
    col_zero = (col == '0);

    if (CmpW'(col) + CmpW'(1) >= eff_width) begin
      col_cnt_d   = '0;
      first_row_d = 1'b0;
    end else begin
      col_cnt_d   = col + ColW'(1);
      first_row_d = top_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      first_row_q <= 1'b1;
      left_q      <= '0;
    end else if (accept) begin
      col_cnt_q   <= col_cnt_d;
      first_row_q <= first_row_d;
      left_q      <= pix_i.pixel;
    end
  end

  // Read the previous row's sample, then replace it with this one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_upper_q   <= row_mem[col];
      row_mem[col] <= pix_i.pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input stage payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q    <= pix_i.pixel;
      s1_left_q     <= col_zero ? '0 : left_q;
      s1_top_q      <= top_row;
      s1_col_zero_q <= col_zero;
    end
  end

  // Drop neighbours that lie outside the plane
  assign upper      = s1_top_q ? '0 : s1_upper_q;
  assign upper_left = (s1_top_q || s1_col_zero_q) ? '0 : upper_left_q;

  ppr_predict u_predict (
    .pixel_i      (s1_pixel_q),
    .left_i       (s1_left_q),
    .upper_i      (upper),
    .upper_left_i (upper_left),
    .residual_o   (residual)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      upper_left_q <= '0;
    end else if (s1_adv) begin
      out_valid_q  <= 1'b1;
      upper_left_q <= upper;
    end else if (res_o.ready) begin
      out_valid_q  <= 1'b0;
    end
  end

  // Hold the residual until it is taken
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= residual;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.residual = out_res_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PixelW      = ppr_pkg::PixelW;
  localparam int unsigned PlaneWidthW = ppr_pkg::PlaneWidthW;
  localparam int unsigned MaxWidth    = ppr_pkg::MaxWidth;

  // Cycles without any accepted request before the run is abandoned
  localparam int unsigned StuckLimit = 1000;
  // Random samples to send across planes of random width
  localparam int unsigned RandomSamples = 1400;
  // Cycles to keep watching the result port once everything has arrived
  localparam int unsigned TailCycles = 8;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              top_left;
  } sample_t;

  logic clk_i;
  logic rst_ni;

  ppr_cfg_if cfg_if ();
  ppr_pix_if pix_if ();
  ppr_res_if res_if ();

  plane_predictive_residual_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  // Samples waiting to be sent, and the residuals they must produce
  sample_t           sample_q[$];
  logic [PixelW-1:0] residual_q[$];

  // Predicted state of the block: previous row, neighbours, raster position
  logic [PixelW-1:0]      row_mem [MaxWidth];
  logic [PixelW-1:0]      left_px;
  logic [PixelW-1:0]      upleft_px;
  int unsigned            col_cnt;
  bit                     top_row;
  logic [PlaneWidthW-1:0] plane_w;
  // Row store entries written since reset; they always form a prefix
  int unsigned            row_fill;

  // Handshake flags, sampled at the rising edge and used at the falling one
  bit pix_fire;
  bit res_fire;
  bit cfg_fire;

  // Idle control of both sides
  int unsigned src_gap;
  int unsigned sink_wait;
  bit          src_calm;
  bit          sink_calm;

  int unsigned stuck_cycles;
  int unsigned err_count;
  sample_t     next_sample;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Zero acts as one; anything above the row store depth saturates to it
  function automatic int unsigned row_length(input logic [PlaneWidthW-1:0] w);
    if (w == '0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return 32'(w);
  endfunction

  // Advance the predicted state by one sample and return its residual
  function automatic logic [PixelW-1:0] residual_of(input logic [PixelW-1:0] px,
                                                    input logic top_left);
    int unsigned       eff;
    int unsigned       col;
    logic [PixelW-1:0] l;
    logic [PixelW-1:0] t;
    logic [PixelW-1:0] lt;
    logic [PixelW-1:0] pred;
    int                num;
    int                quo;
    eff = row_length(plane_w);
    // A marked sample restarts the plane; a shrunk width wraps to a new row
    if (top_left) begin
      col_cnt = 0;
      top_row = 1'b1;
    end else if (col_cnt >= eff) begin
      col_cnt = 0;
      top_row = 1'b0;
    end
    col = col_cnt;
    l = (col == 0) ? '0 : left_px;
    if (top_row) begin
      t  = '0;
      lt = '0;
    end else begin
      t  = row_mem[col];
      lt = (col == 0) ? '0 : upleft_px;
    end
    // Signed integer divide truncates toward zero; keep the low byte
    num  = 2 * int'(l) + 2 * int'(t) - int'(lt);
    quo  = num / 3;
    pred = quo[PixelW-1:0];
    row_mem[col] = px;
    if (col + 1 > row_fill) row_fill = col + 1;
    upleft_px = t;
    left_px   = px;
    if (col + 1 >= eff) begin
      col_cnt = 0;
      top_row = 1'b0;
    end else begin
      col_cnt = col + 1;
    end
    return px - pred;
  endfunction

  // Sender: hold a request until taken, then wait the drawn gap
  always @(negedge clk_i) begin
    if (pix_fire) src_gap = src_calm ? 0 : $urandom_range(0, 3);
    if (pix_if.valid && !pix_fire) begin
      // hold the current request
    end else if (src_gap > 0) begin
      pix_if.valid <= 1'b0;
      src_gap--;
    end else if (sample_q.size() != 0) begin
      next_sample = sample_q.pop_front();
      pix_if.valid          <= 1'b1;
      pix_if.pixel          <= next_sample.pixel;
      pix_if.first_of_plane <= next_sample.top_left;
    end else begin
      pix_if.valid <= 1'b0;
    end
  end

  // Receiver: stall for the drawn number of cycles after every result
  always @(negedge clk_i) begin
    if (res_fire) sink_wait = sink_calm ? 0 : $urandom_range(0, 3);
    if (sink_wait > 0) begin
      res_if.ready <= 1'b0;
      sink_wait--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted sample, check each accepted residual
  always @(posedge clk_i) begin
    pix_fire = (pix_if.valid === 1'b1) && (pix_if.ready === 1'b1);
    res_fire = (res_if.valid === 1'b1) && (res_if.ready === 1'b1);
    cfg_fire = (cfg_if.valid === 1'b1) && (cfg_if.ready === 1'b1);
    if (cfg_fire) plane_w = cfg_if.plane_width;
    if (pix_fire) residual_q.push_back(residual_of(pix_if.pixel, pix_if.first_of_plane));
    if (res_fire) begin
      if (residual_q.size() == 0) begin
        report_mismatch($sformatf("residual %0d with none expected", res_if.residual));
      end else if (res_if.residual !== residual_q[0]) begin
        report_mismatch($sformatf("residual %0d, expected %0d",
                                  res_if.residual, residual_q[0]));
        void'(residual_q.pop_front());
      end else begin
        void'(residual_q.pop_front());
      end
    end
    // Watchdog: count cycles in which no channel moves a request
    if (!rst_ni || pix_fire || res_fire || cfg_fire) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("plane_predictive_residual_unit test failed");
      $finish;
    end
  end

  task automatic push_sample(input logic [PixelW-1:0] px, input logic top_left);
    sample_t s;
    s.pixel    = px;
    s.top_left = top_left;
    sample_q.push_back(s);
  endtask

  // Wait until every queued sample has been taken and every residual seen;
  // look at the rising edge, where the sender's outputs have settled
  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || pix_if.valid || residual_q.size() != 0);
  endtask

  // Write the row length; only called while the block is idle
  task automatic write_plane_width(input logic [PlaneWidthW-1:0] w);
    @(negedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.plane_width <= w;
    do @(posedge clk_i);
    while (!((cfg_if.valid === 1'b1) && (cfg_if.ready === 1'b1)));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // A wider row than the store has seen would read unwritten entries, so
  // restart the plane whenever the new width outgrows the filled prefix
  function automatic bit must_restart();
    return row_length(plane_w) > row_fill;
  endfunction

  // Queue one plane segment with random content, mostly well-formed
  task automatic queue_segment(input int unsigned n, input bit restart);
    logic [PixelW-1:0] px;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       px = '0;
        1:       px = '1;
        default: px = PixelW'($urandom_range(0, 255));
      endcase
      if (i == 0) push_sample(px, restart);
      else push_sample(px, ($urandom_range(0, 49) == 0));
    end
  endtask

  task automatic pick_idling();
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int unsigned            sent;
    int unsigned            n;
    logic [PlaneWidthW-1:0] w;

    // Drive every input to a known value and hold reset
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.plane_width    = '0;
    pix_if.valid          = 1'b0;
    pix_if.pixel          = '0;
    pix_if.first_of_plane = 1'b0;
    res_if.ready          = 1'b0;
    pix_fire              = 1'b0;
    res_fire              = 1'b0;
    cfg_fire              = 1'b0;
    src_gap               = 0;
    sink_wait             = 0;
    src_calm              = 1'b0;
    sink_calm             = 1'b0;
    stuck_cycles          = 0;
    err_count             = 0;
    // Predicted reset state
    foreach (row_mem[i]) row_mem[i] = '0;
    left_px   = '0;
    upleft_px = '0;
    col_cnt   = 0;
    top_row   = 1'b1;
    plane_w   = ppr_pkg::PlaneWidthRst;
    row_fill  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three-wide plane: top-left passes, top row, left column, a negative
    // numerator and a prediction that overflows the byte
    write_plane_width(PlaneWidthW'(3));
    pick_idling();
    push_sample(8'd255, 1'b1);
    push_sample(8'd255, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd128, 1'b0);
    push_sample(8'd1,   1'b0);
    // restart the plane in the middle of a row
    push_sample(8'd200, 1'b1);
    push_sample(8'd3,   1'b0);
    push_sample(8'd254, 1'b0);
    wait_drained();

    // Width zero acts as one: every sample sits in the left column
    write_plane_width('0);
    pick_idling();
    push_sample(8'd9,   1'b0);
    push_sample(8'd250, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd255, 1'b0);
    wait_drained();

    // Largest register value saturates to the store depth; stay in the top row
    write_plane_width('1);
    pick_idling();
    push_sample(8'd60, 1'b1);
    push_sample(8'd61, 1'b0);
    push_sample(8'd0,  1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd7,  1'b0);
    wait_drained();

    // Shrink below the current column: the next sample opens a lower row
    write_plane_width(PlaneWidthW'(2));
    pick_idling();
    push_sample(8'd11,  1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd128, 1'b0);
    wait_drained();

    write_plane_width(PlaneWidthW'(1));
    pick_idling();
    push_sample(8'd255, 1'b0);
    push_sample(8'd0,   1'b0);
    push_sample(8'd77,  1'b0);
    wait_drained();

    // Random segments, each separated by a full drain and a width write
    sent = 0;
    while (sent < RandomSamples) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = PlaneWidthW'(1);
        2:       w = PlaneWidthW'($urandom_range(MaxWidth + 1, 4095));
        3, 4:    w = PlaneWidthW'($urandom_range(17, 300));
        default: w = PlaneWidthW'($urandom_range(2, 16));
      endcase
      write_plane_width(w);
      pick_idling();
      n = (row_length(w) > 300) ? $urandom_range(20, 60) : $urandom_range(20, 100);
      queue_segment(n, must_restart() || ($urandom_range(0, 2) == 0));
      sent += n;
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (TailCycles) @(posedge clk_i);
    if (residual_q.size() != 0)
      report_mismatch($sformatf("%0d residuals never arrived", residual_q.size()));
    if (err_count == 0) begin
      $display("plane_predictive_residual_unit test passed");
    end else begin
      $display("plane_predictive_residual_unit test failed");
    end
    $finish;
  end

endmodule

// ----- plane_predictive_residual_unit.f -----
rtl/core/ppr_pkg.sv
rtl/core/ppr_cfg_if.sv
rtl/core/ppr_pix_if.sv
rtl/core/ppr_res_if.sv
rtl/core/ppr_predict.sv
rtl/core/plane_predictive_residual_unit.sv
test/testbench.sv
